// File: hw/rtl/line_pixel_stepper_defines.svh
// assertion macros used by the line pixel stepper rtl
// no dependencies; included by lps_step, the module that checks itself
`ifndef LINE_PIXEL_STEPPER_DEFINES_SVH
`define LINE_PIXEL_STEPPER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LPS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define LPS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/lps_pkg.sv
// types and constants of the line pixel stepper
// no dependencies; used by every module of the block
package lps_pkg;

  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 5;
  localparam int ADDR_W     = 30;
  localparam int PIX_W      = 12;
  localparam int CFG_W      = 12;
  localparam int STRIDE_W   = 16;
  // wide enough for a coordinate of up to 16 bits plus an offset
  localparam int CALC_W     = 17;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET  = 16'd5464;
  localparam logic [CFG_W-1:0]    X_LIMIT_RESET = 12'd1350;
  localparam logic [CFG_W-1:0]    Y_LIMIT_RESET = 12'd750;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef enum logic [2:0] {
    REG_X_OFFSET    = 3'd0,
    REG_Y_OFFSET    = 3'd1,
    REG_STRIDE      = 3'd2,
    REG_WIDE_PIXELS = 3'd3,
    REG_X_LIMIT     = 3'd4,
    REG_Y_LIMIT     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0]    x_offset;
    logic [CFG_W-1:0]    y_offset;
    logic [STRIDE_W-1:0] stride_bytes;
    logic                wide_pixels;
    logic [CFG_W-1:0]    x_limit;
    logic [CFG_W-1:0]    y_limit;
  } cfg_t;

endpackage

// File: hw/rtl/lps_cfg_regs.sv
// apb register file of the line pixel stepper
// depends on lps_pkg
module lps_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lps_pkg::PADDR_W-1:0]        paddr,
  input  logic [lps_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lps_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output lps_pkg::cfg_t                      cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_offset     <= '0;
      cfg.y_offset     <= '0;
      cfg.stride_bytes <= lps_pkg::STRIDE_RESET;
      cfg.wide_pixels  <= 1'b1;
      cfg.x_limit      <= lps_pkg::X_LIMIT_RESET;
      cfg.y_limit      <= lps_pkg::Y_LIMIT_RESET;
    end else if (wr) begin
      unique case (idx)
        lps_pkg::REG_X_OFFSET:    cfg.x_offset     <= pwdata[lps_pkg::CFG_W-1:0];
        lps_pkg::REG_Y_OFFSET:    cfg.y_offset     <= pwdata[lps_pkg::CFG_W-1:0];
        lps_pkg::REG_STRIDE:      cfg.stride_bytes <= pwdata[lps_pkg::STRIDE_W-1:0];
        lps_pkg::REG_WIDE_PIXELS: cfg.wide_pixels  <= pwdata[0];
        lps_pkg::REG_X_LIMIT:     cfg.x_limit      <= pwdata[lps_pkg::CFG_W-1:0];
        lps_pkg::REG_Y_LIMIT:     cfg.y_limit      <= pwdata[lps_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      lps_pkg::REG_X_OFFSET:    prdata[lps_pkg::CFG_W-1:0]    = cfg.x_offset;
      lps_pkg::REG_Y_OFFSET:    prdata[lps_pkg::CFG_W-1:0]    = cfg.y_offset;
      lps_pkg::REG_STRIDE:      prdata[lps_pkg::STRIDE_W-1:0] = cfg.stride_bytes;
      lps_pkg::REG_WIDE_PIXELS: prdata[0]                     = cfg.wide_pixels;
      lps_pkg::REG_X_LIMIT:     prdata[lps_pkg::CFG_W-1:0]    = cfg.x_limit;
      lps_pkg::REG_Y_LIMIT:     prdata[lps_pkg::CFG_W-1:0]    = cfg.y_limit;
      default:                  prdata                        = '0;
    endcase
  end

endmodule

// File: hw/rtl/lps_step.sv
// input register, endpoint clamping and error-term stepping
// depends on lps_pkg and line_pixel_stepper_defines.svh
`include "line_pixel_stepper_defines.svh"
module lps_step #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lps_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        opcode,
  input  logic signed [COORD_BITS:0]  start_x,
  input  logic signed [COORD_BITS:0]  start_y,
  input  logic signed [COORD_BITS:0]  end_x,
  input  logic signed [COORD_BITS:0]  end_y,
  output logic                        p_valid,
  input  logic                        p_ready,
  output logic [COORD_BITS-1:0]       p_col,
  output logic [COORD_BITS-1:0]       p_row,
  output logic                        p_last
);

  localparam int C = COORD_BITS;
  localparam int E = COORD_BITS + 2;

  function automatic logic [C-1:0] clamp(input logic signed [C:0] v,
                                         input logic [C-1:0] lim);
    logic [C-1:0] r;
    if (v[C])
      r = '0;
    else if (v[C-1:0] > lim)
      r = lim;
    else
      r = v[C-1:0];
    return r;
  endfunction

  // input register
  logic                i_valid;
  logic                i_op;
  logic signed [C:0]   i_sx, i_sy, i_ex, i_ey;
  logic                take;

  // line state
  logic [C-1:0]        cur_col, cur_row, goal_col, goal_row;
  logic [C-1:0]        delta_col, delta_row;
  logic signed [E-1:0] error_term;
  logic                col_backward, row_backward, active;

  // start set-up
  logic [lps_pkg::CALC_W-1:0] xl_wide, yl_wide;
  logic [C-1:0]        xl, yl;
  logic [C-1:0]        s_col, s_row, g_col, g_row, s_dc, s_dr;
  logic                s_col_fwd, s_row_fwd;
  logic signed [E-1:0] s_err;

  // advance
  logic signed [E-1:0] dc_s, dr_s, a_err;
  logic                step_col, step_row;
  logic [C-1:0]        a_col, a_row;

  logic [C-1:0]        n_col, n_row;
  logic                n_last, produce;

  assign take     = i_valid && (!p_valid || p_ready);
  assign in_ready = !i_valid || (!p_valid || p_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
    end else if (in_ready) begin
      i_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      i_op <= opcode;
      i_sx <= start_x;
      i_sy <= start_y;
      i_ex <= end_x;
      i_ey <= end_y;
    end
  end

  assign xl_wide = {{(lps_pkg::CALC_W-lps_pkg::CFG_W){1'b0}}, cfg.x_limit};
  assign yl_wide = {{(lps_pkg::CALC_W-lps_pkg::CFG_W){1'b0}}, cfg.y_limit};
  assign xl      = xl_wide[C-1:0];
  assign yl      = yl_wide[C-1:0];

  always_comb begin
    s_col     = clamp(i_sx, xl);
    s_row     = clamp(i_sy, yl);
    g_col     = clamp(i_ex, xl);
    g_row     = clamp(i_ey, yl);
    s_col_fwd = s_col < g_col;
    s_row_fwd = s_row < g_row;
    s_dc      = s_col_fwd ? g_col - s_col : s_col - g_col;
    s_dr      = s_row_fwd ? g_row - s_row : s_row - g_row;
    if (s_dc > s_dr)
      s_err = $signed({3'b000, s_dc[C-1:1]});
    else
      s_err = -$signed({3'b000, s_dr[C-1:1]});
  end

  always_comb begin
    dc_s     = $signed({2'b00, delta_col});
    dr_s     = $signed({2'b00, delta_row});
    step_col = error_term > -dc_s;
    step_row = error_term < dr_s;
    a_err    = error_term - (step_col ? dr_s : '0) + (step_row ? dc_s : '0);
    a_col    = cur_col;
    a_row    = cur_row;
    if (step_col)
      a_col = col_backward ? cur_col - 1'b1 : cur_col + 1'b1;
    if (step_row)
      a_row = row_backward ? cur_row - 1'b1 : cur_row + 1'b1;
  end

  always_comb begin
    if (i_op == lps_pkg::OP_START) begin
      n_col  = s_col;
      n_row  = s_row;
      n_last = (s_col == g_col) && (s_row == g_row);
    end else begin
      n_col  = a_col;
      n_row  = a_row;
      n_last = (a_col == goal_col) && (a_row == goal_row);
    end
    produce = take && ((i_op == lps_pkg::OP_START) || active);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col      <= '0;
      cur_row      <= '0;
      goal_col     <= '0;
      goal_row     <= '0;
      delta_col    <= '0;
      delta_row    <= '0;
      error_term   <= '0;
      col_backward <= 1'b0;
      row_backward <= 1'b0;
      active       <= 1'b0;
    end else if (produce) begin
      cur_col <= n_col;
      cur_row <= n_row;
      active  <= !n_last;
      if (i_op == lps_pkg::OP_START) begin
        goal_col     <= g_col;
        goal_row     <= g_row;
        delta_col    <= s_dc;
        delta_row    <= s_dr;
        error_term   <= s_err;
        col_backward <= !s_col_fwd;
        row_backward <= !s_row_fwd;
      end else begin
        error_term <= a_err;
      end
    end
  end

  // pixel register
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (!p_valid || p_ready) begin
      p_valid <= produce;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      p_col  <= n_col;
      p_row  <= n_row;
      p_last <= n_last;
    end
  end

  `LPS_ASSERT_NOW(a_active_not_at_goal, clk, rst, active, !((cur_col == goal_col) && (cur_row == goal_row)), "active line already at its end point")
  `LPS_ASSERT_NEXT(a_last_ends_line, clk, rst, produce && n_last, !active, "end point left the line active")
  `LPS_ASSERT_NEXT(a_idle_advance_silent, clk, rst, take && (i_op == lps_pkg::OP_ADVANCE) && !active, !p_valid, "advance with no line produced a pixel")
  `LPS_ASSERT_NEXT(a_pixel_held, clk, rst, p_valid && !p_ready, p_valid && $stable(p_col) && $stable(p_row) && $stable(p_last), "stalled pixel changed")

endmodule

// File: hw/rtl/lps_addr.sv
// framebuffer address calculation and result register
// depends on lps_pkg
module lps_addr #(
  parameter int COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lps_pkg::cfg_t                     cfg,
  input  logic                              p_valid,
  output logic                              p_ready,
  input  logic [COORD_BITS-1:0]             p_col,
  input  logic [COORD_BITS-1:0]             p_row,
  input  logic                              p_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lps_pkg::PIX_W-1:0]         pixel_x,
  output logic [lps_pkg::PIX_W-1:0]         pixel_y,
  output logic [lps_pkg::ADDR_W-1:0]        byte_address,
  output logic                              last
);

  localparam int W = lps_pkg::CALC_W;

  logic [W-1:0]                  col_ext, row_ext, xoff_ext, yoff_ext, sum_x, sum_y;
  logic [W+1:0]                  scaled_x;
  logic [W+lps_pkg::STRIDE_W-1:0] row_prod;
  logic [lps_pkg::ADDR_W-1:0]    addr;

  assign p_ready = !out_valid || out_ready;

  always_comb begin
    col_ext  = {{(W-COORD_BITS){1'b0}}, p_col};
    row_ext  = {{(W-COORD_BITS){1'b0}}, p_row};
    xoff_ext = {{(W-lps_pkg::CFG_W){1'b0}}, cfg.x_offset};
    yoff_ext = {{(W-lps_pkg::CFG_W){1'b0}}, cfg.y_offset};
    sum_x    = col_ext + xoff_ext;
    sum_y    = row_ext + yoff_ext;
    scaled_x = cfg.wide_pixels ? {sum_x, 2'b00} : {1'b0, sum_x, 1'b0};
    row_prod = sum_y * cfg.stride_bytes;
    addr     = row_prod[lps_pkg::ADDR_W-1:0]
             + {{(lps_pkg::ADDR_W-W-2){1'b0}}, scaled_x};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p_ready) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid && p_ready) begin
      pixel_x      <= col_ext[lps_pkg::PIX_W-1:0];
      pixel_y      <= row_ext[lps_pkg::PIX_W-1:0];
      byte_address <= addr;
      last         <= p_last;
    end
  end

endmodule

// File: hw/rtl/line_pixel_stepper.sv
// Line pixel stepper: integer line rasterizer with framebuffer byte addressing.
// Accepts one beat per clock and gives one pixel per clock while the output is not
// stalled. A beat passes an input register, a stepping stage (clamping, set-up and
// one error-term step) and an address stage (one stride multiply), each ending in a
// register. A start beat emits the first pixel of its line, each advance beat emits
// the next one; an advance with no line in progress is consumed without a result.
// Configuration is to be written over the apb port while idle; the block does not check.
// depends on lps_pkg, lps_cfg_regs, lps_step and lps_addr
module line_pixel_stepper #(
  parameter int COORD_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lps_pkg::PADDR_W-1:0]        paddr,
  input  logic [lps_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lps_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               opcode,
  input  logic signed [COORD_BITS:0]         start_x,
  input  logic signed [COORD_BITS:0]         start_y,
  input  logic signed [COORD_BITS:0]         end_x,
  input  logic signed [COORD_BITS:0]         end_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lps_pkg::PIX_W-1:0]          pixel_x,
  output logic [lps_pkg::PIX_W-1:0]          pixel_y,
  output logic [lps_pkg::ADDR_W-1:0]         byte_address,
  output logic                               last
);

  lps_pkg::cfg_t           cfg;
  logic                    p_valid, p_ready, p_last;
  logic [COORD_BITS-1:0]   p_col, p_row;

  lps_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lps_step #(.COORD_BITS(COORD_BITS)) u_step (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .p_valid  (p_valid),
    .p_ready  (p_ready),
    .p_col    (p_col),
    .p_row    (p_row),
    .p_last   (p_last)
  );

  lps_addr #(.COORD_BITS(COORD_BITS)) u_addr (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .p_valid      (p_valid),
    .p_ready      (p_ready),
    .p_col        (p_col),
    .p_row        (p_row),
    .p_last       (p_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .byte_address (byte_address),
    .last         (last)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// testbench for line_pixel_stepper: sends line start and advance beats, predicts every
// pixel (clamping, error-term stepping, byte address) and checks it at the output
// depends on lps_pkg and the line_pixel_stepper rtl
module testbench;

  localparam int CB = 12;

  typedef struct packed {
    logic [lps_pkg::PIX_W-1:0]  x;
    logic [lps_pkg::PIX_W-1:0]  y;
    logic [lps_pkg::ADDR_W-1:0] addr;
    logic                       fin;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lps_pkg::PADDR_W-1:0] paddr = '0;
  logic [lps_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [lps_pkg::APB_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = lps_pkg::OP_START;
  logic signed [CB:0] start_x = '0;
  logic signed [CB:0] start_y = '0;
  logic signed [CB:0] end_x = '0;
  logic signed [CB:0] end_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [lps_pkg::PIX_W-1:0] pixel_x;
  logic [lps_pkg::PIX_W-1:0] pixel_y;
  logic [lps_pkg::ADDR_W-1:0] byte_address;
  logic last;

  line_pixel_stepper #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .byte_address(byte_address), .last(last)
  );

  // predicted block state
  lps_pkg::cfg_t cfg;
  logic [CB-1:0] cur_col = '0, cur_row = '0, goal_col = '0, goal_row = '0;
  int span_col = 0, span_row = 0, err_acc = 0;
  bit col_back = 0, row_back = 0, drawing = 0;

  pixel_t pixels_due[$];
  int mismatches = 0, pixels_checked = 0, beats_sent = 0, lines_started = 0, settings_used = 0;
  bit tx_calm = 0, rx_calm = 0;
  int rx_hold = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("%0t: timed out with %0d pixels outstanding", $time, pixels_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [CB-1:0] clamp_to(logic signed [CB:0] v, logic [CB-1:0] lim);
    int iv;
    iv = v;
    if (iv < 0) return '0;
    if (iv > int'(lim)) return lim;
    return iv[CB-1:0];
  endfunction

  function automatic pixel_t pixel_here();
    longint unsigned a;
    pixel_t p;
    a = (longint'(cur_col) + cfg.x_offset) * (cfg.wide_pixels ? 4 : 2)
      + (longint'(cur_row) + cfg.y_offset) * cfg.stride_bytes;
    p.x = cur_col;
    p.y = cur_row;
    p.addr = a[lps_pkg::ADDR_W-1:0];
    p.fin = (cur_col == goal_col) && (cur_row == goal_row);
    drawing = !p.fin;
    return p;
  endfunction

  function automatic bit trace_pixel(logic op, logic signed [CB:0] sx, logic signed [CB:0] sy,
                                     logic signed [CB:0] ex, logic signed [CB:0] ey,
                                     output pixel_t p);
    int e;
    if (op == lps_pkg::OP_START) begin
      cur_col = clamp_to(sx, cfg.x_limit);
      cur_row = clamp_to(sy, cfg.y_limit);
      goal_col = clamp_to(ex, cfg.x_limit);
      goal_row = clamp_to(ey, cfg.y_limit);
      col_back = !(cur_col < goal_col);
      row_back = !(cur_row < goal_row);
      span_col = (cur_col < goal_col) ? int'(goal_col) - int'(cur_col)
                                      : int'(cur_col) - int'(goal_col);
      span_row = (cur_row < goal_row) ? int'(goal_row) - int'(cur_row)
                                      : int'(cur_row) - int'(goal_row);
      err_acc = (span_col > span_row) ? span_col / 2 : -(span_row / 2);
      p = pixel_here();
      return 1;
    end
    if (!drawing) begin
      p = '0;
      return 0;
    end
    e = err_acc;
    if (e > -span_col) begin
      err_acc -= span_row;
      cur_col = col_back ? cur_col - 1'b1 : cur_col + 1'b1;
    end
    if (e < span_row) begin
      err_acc += span_col;
      cur_row = row_back ? cur_row - 1'b1 : cur_row + 1'b1;
    end
    p = pixel_here();
    return 1;
  endfunction

  function automatic void match_field(string what, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  function automatic logic signed [CB:0] any_coord();
    return (CB+1)'($urandom);
  endfunction

  function automatic logic signed [CB:0] near_coord(int base, int span);
    int v;
    v = base + int'($urandom_range(2 * span)) - span;
    if (v > (1 << CB) - 1) v = (1 << CB) - 1;
    if (v < -(1 << CB)) v = -(1 << CB);
    return v[CB:0];
  endfunction

  // receiver side
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if (rx_calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        mismatches++;
        $display("%0t: pixel x %0d y %0d with none expected", $time, pixel_x, pixel_y);
      end else begin
        want = pixels_due.pop_front();
        match_field("pixel_x", want.x, pixel_x);
        match_field("pixel_y", want.y, pixel_y);
        match_field("byte_address", want.addr, byte_address);
        match_field("last", want.fin, last);
        pixels_checked++;
      end
    end
  end

  task automatic send_beat(logic op, logic signed [CB:0] sx, logic signed [CB:0] sy,
                           logic signed [CB:0] ex, logic signed [CB:0] ey, output bit made);
    pixel_t p;
    if (!tx_calm) begin
      while ($urandom_range(99) < 35) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    opcode <= op;
    start_x <= sx;
    start_y <= sy;
    end_x <= ex;
    end_y <= ey;
    do @(posedge clk); while (!in_ready);
    made = trace_pixel(op, sx, sy, ex, ey, p);
    if (made) pixels_due = {pixels_due, p};
    beats_sent++;
    if (op == lps_pkg::OP_START) lines_started++;
  endtask

  task automatic settle(int extra);
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_and_read(lps_pkg::reg_idx_t r, logic [lps_pkg::APB_DATA_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    match_field(r.name(), v, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(lps_pkg::cfg_t c);
    settle(8);
    write_and_read(lps_pkg::REG_X_OFFSET, lps_pkg::APB_DATA_W'(c.x_offset));
    write_and_read(lps_pkg::REG_Y_OFFSET, lps_pkg::APB_DATA_W'(c.y_offset));
    write_and_read(lps_pkg::REG_STRIDE, lps_pkg::APB_DATA_W'(c.stride_bytes));
    write_and_read(lps_pkg::REG_WIDE_PIXELS, lps_pkg::APB_DATA_W'(c.wide_pixels));
    write_and_read(lps_pkg::REG_X_LIMIT, lps_pkg::APB_DATA_W'(c.x_limit));
    write_and_read(lps_pkg::REG_Y_LIMIT, lps_pkg::APB_DATA_W'(c.y_limit));
    cfg = c;
    settings_used++;
  endtask

  task automatic run_line(logic signed [CB:0] sx, logic signed [CB:0] sy,
                          logic signed [CB:0] ex, logic signed [CB:0] ey,
                          int cap, inout int made_cnt);
    bit m;
    int n;
    n = 0;
    send_beat(lps_pkg::OP_START, sx, sy, ex, ey, m);
    made_cnt += m;
    while (drawing && n < cap) begin
      send_beat(lps_pkg::OP_ADVANCE, any_coord(), any_coord(), any_coord(), any_coord(), m);
      made_cnt += m;
      n++;
    end
  endtask

  task automatic test_directed_lines();
    bit m;
    int made;
    made = 0;
    // corners of the signed range clamp to both limits
    send_beat(lps_pkg::OP_START, -4096, -4096, 4095, 4095, m);
    repeat (3) begin
      send_beat(lps_pkg::OP_ADVANCE, any_coord(), any_coord(), any_coord(), any_coord(), m);
    end
    // restart mid-line, stepping backwards
    send_beat(lps_pkg::OP_START, 4095, 4095, -4096, -4096, m);
    repeat (2) send_beat(lps_pkg::OP_ADVANCE, -4096, 4095, -4096, 4095, m);
    // single-pixel line, then an advance with nothing to draw
    send_beat(lps_pkg::OP_START, 7, 9, 7, 9, m);
    send_beat(lps_pkg::OP_ADVANCE, 4095, -4096, 4095, -4096, m);
    send_beat(lps_pkg::OP_START, -1, -5, -300, -4095, m);
    run_line(3, 10, 5, 3, 16, made);
    // largest address the fields allow
    set_config('{x_offset: 12'hfff, y_offset: 12'hfff, stride_bytes: 16'hffff,
                 wide_pixels: 1'b1, x_limit: 12'hfff, y_limit: 12'hfff});
    run_line(4094, 4095, 4095, 4095, 4, made);
    send_beat(lps_pkg::OP_ADVANCE, 0, 0, 0, 0, m);
  endtask

  task automatic test_backpressure();
    int made;
    made = 0;
    set_config('{x_offset: 12'd17, y_offset: 12'd3, stride_bytes: 16'd2048,
                 wide_pixels: 1'b0, x_limit: 12'hfff, y_limit: 12'hfff});
    tx_calm = 1;
    rx_hold = 150;
    run_line(0, 0, 90, 33, 80, made);
    settle(0);
    tx_calm = 0;
  endtask

  task automatic test_random_phase(lps_pkg::cfg_t c, int beats, bit calm);
    bit m;
    int made, pick, span, bx, by, cap;
    made = 0;
    set_config(c);
    tx_calm = calm;
    rx_calm = calm;
    while (made < beats) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_beat(lps_pkg::OP_ADVANCE, any_coord(), any_coord(), any_coord(), any_coord(), m);
        made += m;
      end else if (pick < 25) begin
        run_line(any_coord(), any_coord(), any_coord(), any_coord(), $urandom_range(30), made);
      end else begin
        span = ($urandom_range(19) == 0) ? 300 : $urandom_range(24);
        bx = $urandom_range(int'(cfg.x_limit));
        by = $urandom_range(int'(cfg.y_limit));
        cap = ($urandom_range(9) == 0) ? $urandom_range(span) : (1 << (CB + 1));
        run_line(near_coord(bx, span), near_coord(by, span),
                 near_coord(bx, span), near_coord(by, span), cap, made);
      end
    end
    tx_calm = 0;
    rx_calm = 0;
  endtask

  function automatic lps_pkg::cfg_t random_settings();
    lps_pkg::cfg_t c;
    c.x_offset = lps_pkg::CFG_W'($urandom);
    c.y_offset = lps_pkg::CFG_W'($urandom);
    c.stride_bytes = lps_pkg::STRIDE_W'($urandom);
    c.wide_pixels = 1'($urandom);
    c.x_limit = lps_pkg::CFG_W'($urandom_range(4095, 16));
    c.y_limit = lps_pkg::CFG_W'($urandom_range(4095, 16));
    return c;
  endfunction

  initial begin
    cfg = '{x_offset: '0, y_offset: '0, stride_bytes: lps_pkg::STRIDE_RESET,
            wide_pixels: 1'b1, x_limit: lps_pkg::X_LIMIT_RESET,
            y_limit: lps_pkg::Y_LIMIT_RESET};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_lines();
    test_backpressure();
    test_random_phase(random_settings(), 450, 1'b0);
    test_random_phase('{x_offset: '0, y_offset: '0, stride_bytes: '0, wide_pixels: 1'b0,
                        x_limit: '0, y_limit: '0}, 60, 1'b0);
    test_random_phase('{x_offset: 12'hfff, y_offset: 12'hfff, stride_bytes: 16'hffff,
                        wide_pixels: 1'b1, x_limit: 12'hfff, y_limit: 12'hfff}, 400, 1'b0);
    test_random_phase('{x_offset: 12'd5, y_offset: '0, stride_bytes: 16'd1, wide_pixels: 1'b0,
                        x_limit: 12'd63, y_limit: 12'd31}, 400, 1'b0);
    test_random_phase(random_settings(), 450, 1'b1);
    settle(12);
    $display("covered %0d beats and %0d line starts; %0d pixels checked over %0d settings",
             beats_sent, lines_started, pixels_checked, settings_used);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: line_pixel_stepper.f
+incdir+hw/rtl
hw/rtl/lps_pkg.sv
hw/rtl/lps_cfg_regs.sv
hw/rtl/lps_step.sv
hw/rtl/lps_addr.sv
hw/rtl/line_pixel_stepper.sv
tb/testbench.sv
